// ===== design/atrf_pkg.sv =====
// shared types, codes and constants of the transmit-request framer
package atrf_pkg;

	// request kinds on the input channel
	typedef enum logic {
		REQ_START   = 1'b0,
		REQ_PAYLOAD = 1'b1
	} req_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_ADDRESS     = 3'd0,
		REG_DEST_SHORT       = 3'd1,
		REG_FRAME_IDENT      = 3'd2,
		REG_BROADCAST_RADIUS = 3'd3,
		REG_TX_OPTIONS       = 3'd4
	} reg_idx_t;

	// register reset values
	localparam logic [63:0] DEST_ADDRESS_RST     = 64'h0013_A200_4190_915D;
	localparam logic [15:0] DEST_SHORT_RST       = 16'hFFFE;
	localparam logic [7:0]  FRAME_IDENT_RST      = 8'h01;
	localparam logic [7:0]  BROADCAST_RADIUS_RST = 8'h00;
	localparam logic [7:0]  TX_OPTIONS_RST       = 8'h40;

	// frame constants
	localparam logic [7:0]  START_DELIM   = 8'h7E;
	localparam logic [7:0]  API_TX_REQ    = 8'h10;
	localparam logic [15:0] LEN_OVERHEAD  = 16'd14;

	// byte positions within the frame sequence
	localparam int          IDX_W         = 5;
	localparam logic [IDX_W-1:0] IDX_DELIM     = 5'd0;
	localparam logic [IDX_W-1:0] IDX_LEN_HI    = 5'd1;
	localparam logic [IDX_W-1:0] IDX_LEN_LO    = 5'd2;
	localparam logic [IDX_W-1:0] IDX_API       = 5'd3;
	localparam logic [IDX_W-1:0] IDX_FRAME_ID  = 5'd4;
	localparam logic [IDX_W-1:0] IDX_ADDR0     = 5'd5;
	localparam logic [IDX_W-1:0] IDX_ADDR1     = 5'd6;
	localparam logic [IDX_W-1:0] IDX_ADDR2     = 5'd7;
	localparam logic [IDX_W-1:0] IDX_ADDR3     = 5'd8;
	localparam logic [IDX_W-1:0] IDX_ADDR4     = 5'd9;
	localparam logic [IDX_W-1:0] IDX_ADDR5     = 5'd10;
	localparam logic [IDX_W-1:0] IDX_ADDR6     = 5'd11;
	localparam logic [IDX_W-1:0] IDX_ADDR7     = 5'd12;
	localparam logic [IDX_W-1:0] IDX_SHORT_HI  = 5'd13;
	localparam logic [IDX_W-1:0] IDX_SHORT_LO  = 5'd14;
	localparam logic [IDX_W-1:0] IDX_RADIUS    = 5'd15;
	localparam logic [IDX_W-1:0] IDX_OPTIONS   = 5'd16;
	localparam logic [IDX_W-1:0] IDX_CHECKSUM  = 5'd17;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// command kinds handed from front to back
	typedef enum logic {
		CMD_HEADER  = 1'b0,
		CMD_PAYLOAD = 1'b1
	} cmd_kind_t;

	// one command: header with length, or one payload byte
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] len;
		logic [7:0] data;
		logic       close;
	} cmd_t;

	// configuration register set
	typedef struct packed {
		logic [63:0] dest_address;
		logic [15:0] dest_short;
		logic [7:0]  frame_ident;
		logic [7:0]  broadcast_radius;
		logic [7:0]  tx_options;
	} cfg_t;

endpackage

// ===== design/atrf_cfg.sv =====
// configuration register bank of the transmit-request framer
module atrf_cfg
	import atrf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg          = cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_address     <= DEST_ADDRESS_RST;
			cfg_q.dest_short       <= DEST_SHORT_RST;
			cfg_q.frame_ident      <= FRAME_IDENT_RST;
			cfg_q.broadcast_radius <= BROADCAST_RADIUS_RST;
			cfg_q.tx_options       <= TX_OPTIONS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEST_ADDRESS:     cfg_q.dest_address     <= cfg_data;
				REG_DEST_SHORT:       cfg_q.dest_short       <= cfg_data[15:0];
				REG_FRAME_IDENT:      cfg_q.frame_ident      <= cfg_data[7:0];
				REG_BROADCAST_RADIUS: cfg_q.broadcast_radius <= cfg_data[7:0];
				REG_TX_OPTIONS:       cfg_q.tx_options       <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== design/atrf_front.sv =====
// front end: accepts items, tracks the open frame and issues commands
module atrf_front
	import atrf_pkg::*;
#(
	parameter int MAX_PAYLOAD = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] msg_length,
	input  logic [7:0] payload_byte,
	output logic       push,
	output cmd_t       push_cmd,
	input  logic       queue_full
);

	logic       in_frame_q;
	logic [7:0] remaining_q;
	logic       is_start;
	logic       drop;
	logic       accept;
	logic [7:0] len_sat;
	logic [7:0] remaining_dec;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign is_start = (req_type == REQ_START);

	// payload outside an open frame is dropped
	assign drop = !is_start && (!in_frame_q || (remaining_q == 8'd0));

	// length saturation
	assign len_sat = (32'(msg_length) > 32'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : msg_length;

	assign remaining_dec = remaining_q - 8'd1;

	// command to the back end
	always_comb begin
		push_cmd = '0;
		if (is_start) begin
			push_cmd.kind  = CMD_HEADER;
			push_cmd.len   = len_sat;
			push_cmd.close = (len_sat == 8'd0);
		end else begin
			push_cmd.kind  = CMD_PAYLOAD;
			push_cmd.data  = payload_byte;
			push_cmd.close = (remaining_dec == 8'd0);
		end
	end

	assign push = accept && !drop;

	// frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			remaining_q <= 8'd0;
		end else if (accept) begin
			if (is_start) begin
				in_frame_q  <= (len_sat != 8'd0);
				remaining_q <= len_sat;
			end else if (drop) begin
				in_frame_q <= 1'b0;
			end else begin
				remaining_q <= remaining_dec;
				if (remaining_dec == 8'd0) begin
					in_frame_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== design/atrf_queue.sv =====
// short command queue between the front and back ends
module atrf_queue
	import atrf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full       = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== design/atrf_back.sv =====
// back end: expands commands into frame bytes and keeps the checksum
module atrf_back
	import atrf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       head_valid,
	input  cmd_t       head_cmd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       frame_end,
	output logic       run_last
);

	cmd_t             cur_q;
	logic             cur_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             frame_end_q;
	logic             run_last_q;

	logic             adv;
	logic             emit;
	logic [7:0]       byte_c;
	logic             end_c;
	logic             last_c;
	logic             done_c;
	logic [IDX_W-1:0] idx_next;
	logic [7:0]       sum_next;
	logic [15:0]      total;
	logic [7:0]       hdr_byte;

	assign adv   = !out_valid_q || out_ready;
	assign emit  = cur_valid_q && adv;
	assign total = 16'(cur_q.len) + LEN_OVERHEAD;

	// header byte selection
	always_comb begin
		case (idx_q)
			IDX_DELIM:    hdr_byte = START_DELIM;
			IDX_LEN_HI:   hdr_byte = total[15:8];
			IDX_LEN_LO:   hdr_byte = total[7:0];
			IDX_API:      hdr_byte = API_TX_REQ;
			IDX_FRAME_ID: hdr_byte = cfg.frame_ident;
			IDX_ADDR0:    hdr_byte = cfg.dest_address[63:56];
			IDX_ADDR1:    hdr_byte = cfg.dest_address[55:48];
			IDX_ADDR2:    hdr_byte = cfg.dest_address[47:40];
			IDX_ADDR3:    hdr_byte = cfg.dest_address[39:32];
			IDX_ADDR4:    hdr_byte = cfg.dest_address[31:24];
			IDX_ADDR5:    hdr_byte = cfg.dest_address[23:16];
			IDX_ADDR6:    hdr_byte = cfg.dest_address[15:8];
			IDX_ADDR7:    hdr_byte = cfg.dest_address[7:0];
			IDX_SHORT_HI: hdr_byte = cfg.dest_short[15:8];
			IDX_SHORT_LO: hdr_byte = cfg.dest_short[7:0];
			IDX_RADIUS:   hdr_byte = cfg.broadcast_radius;
			IDX_OPTIONS:  hdr_byte = cfg.tx_options;
			default:      hdr_byte = 8'h00;
		endcase
	end

	// byte, flags and checksum for the current step
	always_comb begin
		byte_c   = 8'h00;
		end_c    = 1'b0;
		last_c   = 1'b0;
		done_c   = 1'b0;
		idx_next = idx_q + IDX_W'(1);
		sum_next = sum_q;
		if (idx_q == IDX_CHECKSUM) begin
			byte_c = ~sum_q;
			end_c  = 1'b1;
			last_c = 1'b1;
			done_c = 1'b1;
		end else if (cur_q.kind == CMD_HEADER) begin
			byte_c = hdr_byte;
			if (idx_q == IDX_DELIM) begin
				sum_next = 8'h00;
			end else if (idx_q >= IDX_API) begin
				sum_next = sum_q + hdr_byte;
			end
			if (idx_q == IDX_OPTIONS) begin
				if (cur_q.close) begin
					idx_next = IDX_CHECKSUM;
				end else begin
					last_c = 1'b1;
					done_c = 1'b1;
				end
			end
		end else begin
			byte_c   = cur_q.data;
			sum_next = sum_q + cur_q.data;
			if (cur_q.close) begin
				idx_next = IDX_CHECKSUM;
			end else begin
				last_c = 1'b1;
				done_c = 1'b1;
			end
		end
	end

	assign pop = head_valid && (!cur_valid_q || (emit && done_c));

	// command sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			sum_q       <= 8'h00;
		end else begin
			if (emit) begin
				sum_q <= sum_next;
			end
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (emit && done_c) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_next;
			end
		end
	end

	// command payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_cmd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= byte_c;
			frame_end_q <= end_c;
			run_last_q  <= last_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

endmodule

// ===== design/api_transmit_request_framer.sv =====
// top level of the API transmit-request framer
//
// Input channel (in_valid/in_ready): req_type 0 opens a frame of msg_length
// payload bytes (saturated to MAX_PAYLOAD), req_type 1 carries one payload
// byte. Output channel (out_valid/out_ready) gives the frame one byte per item,
// frame_end marks the checksum byte and run_last the final byte caused by an
// input item. Configuration channel (cfg_valid/cfg_ready) writes the address,
// frame id, radius and option registers; it is always ready.
// Throughput: one output byte per cycle while out_ready is high and commands
// are queued. A start item yields 17 bytes (18 when the length is zero); a
// payload item yields one byte (two on the last byte of a frame). Payload items
// are taken at one per cycle while the queue is not full. The first byte of
// an item passes the queue write, command register and output register.
// A four-entry command queue separates the accepting front end from the byte
// sequencer, so items keep being taken while header bytes are going out.
// When the receiver stalls, the output register holds its byte, the sequencer
// pauses and the queue fills; in_ready drops once it is full.
// Reset clears the frame state, empties the queue and restores the default
// register values. Payload items outside an open frame are dropped.
module api_transmit_request_framer
	import atrf_pkg::*;
#(
	parameter int MAX_PAYLOAD = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	input  logic [7:0]           msg_length,
	input  logic [7:0]           payload_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 frame_end,
	output logic                 run_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	cfg_t cfg;
	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	// configuration registers
	atrf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// item intake and frame tracking
	atrf_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.msg_length   (msg_length),
		.payload_byte (payload_byte),
		.push         (push),
		.push_cmd     (push_cmd),
		.queue_full   (queue_full)
	);

	// command queue
	atrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// byte sequencer and output register
	atrf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.frame_end  (frame_end),
		.run_last   (run_last)
	);

endmodule
